[src/rpn_pkg.sv]
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Opcodes
  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_SUB        = 3'd1;
  localparam logic [2:0] OP_MUL        = 3'd2;
  localparam logic [2:0] OP_DIV        = 3'd3;
  localparam logic [2:0] OP_PUSH_CONST = 3'd4;
  localparam logic [2:0] OP_PUSH_VAR   = 3'd5;

  // End status codes
  localparam logic [1:0] END_OK   = 2'd0;
  localparam logic [1:0] END_MANY = 2'd1;
  localparam logic [1:0] END_NONE = 2'd2;

  // Configuration register map
  localparam int          PADDR_W   = 4;
  localparam logic [1:0] REG_VAR_A = 2'd0;
  localparam logic [1:0] REG_VAR_B = 2'd1;
  localparam logic [1:0] REG_VAR_C = 2'd2;
  localparam logic [1:0] REG_VAR_D = 2'd3;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] constant_value;
    logic [1:0]               variable_index;
    logic                     last_instruction;
  } instr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               end_status;
    logic                     instruction_error_seen;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [2:0]        op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

[src/rpn_alu.sv]
module rpn_alu (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::alu_req_t req,
  output rpn_pkg::alu_rsp_t rsp
);

  typedef enum logic {AL_IDLE, AL_DIV} alu_state_t;

  localparam int W  = rpn_pkg::DATA_W;
  localparam int SW = $clog2(W);

  alu_state_t            state;
  logic [W-1:0]          rem;
  logic [W-1:0]          quo;
  logic [W-1:0]          dvs;
  logic                  neg;
  logic [SW-1:0]         step;
  logic [W:0]            rem_sh;
  logic [W:0]            diff;
  logic [W-1:0]          rem_next;
  logic [W-1:0]          quo_next;
  logic [W-1:0]          mul_lo;
  logic                  quick_op;

  assign mul_lo   = req.a * req.b;
  assign quick_op = (req.op == rpn_pkg::OP_ADD) || (req.op == rpn_pkg::OP_SUB) ||
                    (req.op == rpn_pkg::OP_MUL);

  // One restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem, quo[W-1]};
    diff   = rem_sh - {1'b0, dvs};
    if (!diff[W]) begin
      rem_next = diff[W-1:0];
      quo_next = {quo[W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[W-1:0];
      quo_next = {quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= AL_IDLE;
      rsp.done <= 1'b0;
    end else begin
      unique case (state)
        AL_IDLE: begin
          rsp.done <= req.start && quick_op;
          if (req.start) begin
            unique case (req.op)
              rpn_pkg::OP_ADD: begin
                rsp.result <= req.a + req.b;
              end
              rpn_pkg::OP_SUB: begin
                rsp.result <= req.a - req.b;
              end
              rpn_pkg::OP_MUL: begin
                rsp.result <= mul_lo;
              end
              default: begin
                rem   <= '0;
                quo   <= req.a[W-1] ? (W'(0) - req.a) : req.a;
                dvs   <= req.b[W-1] ? (W'(0) - req.b) : req.b;
                neg   <= req.a[W-1] ^ req.b[W-1];
                step  <= '0;
                state <= AL_DIV;
              end
            endcase
          end
        end
        AL_DIV: begin
          rem      <= rem_next;
          quo      <= quo_next;
          step     <= step + 1'b1;
          rsp.done <= (step == SW'(W - 1));
          if (step == SW'(W - 1)) begin
            rsp.result <= neg ? (W'(0) - quo_next) : quo_next;
            state      <= AL_IDLE;
          end
        end
        default: begin
          rsp.done <= 1'b0;
          state    <= AL_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rpn_stack_evaluator.sv]
// Reverse-Polish evaluator: each request on instr is one instruction acting on a
// 16-entry operand stack (add, sub, mul, div pop two and push one; push constant and
// push variable push one, the variables being APB registers 0x0, 0x4, 0x8, 0xC).
// A bad instruction (too few operands, full stack, unknown opcode, divide by zero) is
// skipped and sets a sticky error flag. On the instruction marked last a single result
// request carries the remaining value and end status, and the stack and flag clear.
// From acceptance back to ready a push passes DECODE and FINISH, an arithmetic op
// DECODE, RD_L, EXEC, WAIT and FINISH; a divide stays in WAIT while the bit-serial
// divider in the shared ALU retires one quotient bit per cycle. The stack is one RAM
// with a single registered read port, so the two operands are fetched in successive
// cycles. A last instruction also passes EMIT, held there until the previous result
// is taken. A pending result does not stop new instructions from being accepted.
module rpn_stack_evaluator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         instr_valid,
  output logic                         instr_ready,
  input  rpn_pkg::instr_t              instr,
  output logic                         result_valid,
  input  logic                         result_ready,
  output rpn_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpn_pkg::PADDR_W-1:0]  paddr,
  input  logic [rpn_pkg::DATA_W-1:0]   pwdata,
  output logic [rpn_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int AW = rpn_pkg::ADDR_W;
  localparam int CW = rpn_pkg::COUNT_W;
  localparam int W  = rpn_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_RD_L, S_EXEC, S_WAIT, S_FINISH, S_EMIT
  } state_t;

  state_t            state;
  logic [2:0]        op_q;
  logic [W-1:0]      cval_q;
  logic [1:0]        vidx_q;
  logic              last_q;
  logic [CW-1:0]     count;
  logic              err;
  logic [W-1:0]      opb;

  logic [W-1:0]      var_a;
  logic [W-1:0]      var_b;
  logic [W-1:0]      var_c;
  logic [W-1:0]      var_d;

  logic [W-1:0]      stack_mem [rpn_pkg::STACK_DEPTH];
  logic [W-1:0]      rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [W-1:0]      wr_data;

  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic              is_arith;
  logic              is_push;
  logic              stack_full;
  logic [W-1:0]      var_sel;
  logic [W-1:0]      push_value;
  logic              div_by_zero;

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;

  assign pready      = 1'b1;
  assign instr_ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Configuration registers: write on the APB access phase, read back by index
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      var_a <= '0;
      var_b <= '0;
      var_c <= '0;
      var_d <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        rpn_pkg::REG_VAR_A: var_a <= pwdata;
        rpn_pkg::REG_VAR_B: var_b <= pwdata;
        rpn_pkg::REG_VAR_C: var_c <= pwdata;
        rpn_pkg::REG_VAR_D: var_d <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rpn_pkg::REG_VAR_A: prdata = var_a;
      rpn_pkg::REG_VAR_B: prdata = var_b;
      rpn_pkg::REG_VAR_C: prdata = var_c;
      default:            prdata = var_d;
    endcase
  end

  // Variable chosen by a push-variable instruction
  always_comb begin
    unique case (vidx_q)
      rpn_pkg::REG_VAR_A: var_sel = var_a;
      rpn_pkg::REG_VAR_B: var_sel = var_b;
      rpn_pkg::REG_VAR_C: var_sel = var_c;
      default:            var_sel = var_d;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------------
  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign is_arith   = (op_q == rpn_pkg::OP_ADD) || (op_q == rpn_pkg::OP_SUB) ||
                      (op_q == rpn_pkg::OP_MUL) || (op_q == rpn_pkg::OP_DIV);
  assign is_push    = (op_q == rpn_pkg::OP_PUSH_CONST) || (op_q == rpn_pkg::OP_PUSH_VAR);
  assign stack_full = (count == CW'(rpn_pkg::STACK_DEPTH));
  assign push_value = (op_q == rpn_pkg::OP_PUSH_CONST) ? cval_q : var_sel;
  assign div_by_zero = (op_q == rpn_pkg::OP_DIV) && (opb == '0);

  // ---------------------------------------------------------------------------
  // Operand stack RAM: one write port, one registered read port.
  // Fetch the right operand in DECODE, the left one in RD_L; otherwise keep the
  // bottom entry on the read port for the end-of-program result.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state)
      S_DECODE: rd_addr = count_m1[AW-1:0];
      S_RD_L:   rd_addr = count_m2[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_m2[AW-1:0];
    wr_data = alu_rsp.result;
    if (state == S_DECODE) begin
      wr_en   = is_push && !stack_full;
      wr_addr = count[AW-1:0];
      wr_data = push_value;
    end else if (state == S_WAIT) begin
      wr_en   = alu_rsp.done;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic unit: left operand straight off the read port, right held
  // ---------------------------------------------------------------------------
  assign alu_req.start = (state == S_EXEC) && !div_by_zero;
  assign alu_req.op    = op_q;
  assign alu_req.a     = rd_data;
  assign alu_req.b     = opb;

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Drop the result once taken; in EMIT the reload below decides
      if (result_valid && result_ready && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (instr_valid) begin
            op_q   <= instr.operation;
            cval_q <= instr.constant_value;
            vidx_q <= instr.variable_index;
            last_q <= instr.last_instruction;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (is_arith) begin
            if (count < CW'(2)) begin
              err   <= 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_RD_L;
            end
          end else if (is_push) begin
            if (stack_full) begin
              err <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            state <= S_FINISH;
          end else begin
            // Unknown opcode: skip it
            err   <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_RD_L: begin
          opb   <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (div_by_zero) begin
            err   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            count <= count_m1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // Hold until the result register is free
          if (!result_valid || result_ready) begin
            result_valid                  <= 1'b1;
            result.instruction_error_seen <= err;
            if (count == CW'(1)) begin
              result.result_value <= rd_data;
              result.end_status   <= rpn_pkg::END_OK;
            end else if (count > CW'(1)) begin
              result.result_value <= '0;
              result.end_status   <= rpn_pkg::END_MANY;
            end else begin
              result.result_value <= '0;
              result.end_status   <= rpn_pkg::END_NONE;
            end
            count <= '0;
            err   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/rpn_checker.sv]
module rpn_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         instr_valid,
  input logic                         instr_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input rpn_pkg::result_t             result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Only a single remaining value is reported as a value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_status != rpn_pkg::END_OK |-> result.result_value == '0)
    else $error("non-zero value with failing end status");

  // Ready is low in the cycle after an accepted instruction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    instr_valid && instr_ready |=> !instr_ready)
    else $error("ready straight after an accepted instruction");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (.*);
